@@ rtl/json_string_unescaper_macros.svh @@
// Assertion macros shared by the JSON string unescaper RTL.
// Include by bare file name; no other dependencies.
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

@@ rtl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
// No dependencies; imported by all unescaper modules.
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // One queued command: up to three result bytes that share one kind.
    typedef struct packed {
        logic [1:0] count;
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/jsu_front.sv @@
// Front end of the unescaper: parses input bytes and builds result commands.
// Depends on jsu_pkg and json_string_unescaper_macros.svh.
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_full,
    output t_cmd            o_cmd,
    output logic            o_push
);

    `include "json_string_unescaper_macros.svh"

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    t_mode       r_mode, n_mode;
    logic [11:0] r_accum, n_accum;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            hex_val = i_in_byte[3:0];
        end else if (i_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hex_val = i_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign accept = i_valid && !i_full;
    assign code   = {r_accum, hex_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_accum   <= '0;
            r_hex_cnt <= '0;
        end else begin
            r_mode    <= n_mode;
            r_accum   <= n_accum;
            r_hex_cnt <= n_hex_cnt;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_accum   = r_accum;
        n_hex_cnt = r_hex_cnt;
        o_push    = 1'b0;
        o_cmd     = '{count: 2'd1, kind: KIND_ERROR, b0: 8'h00, b1: 8'h00, b2: 8'h00};
        if (accept) begin
            case (r_mode)
                MODE_STR: begin
                    o_push = 1'b1;
                    if (i_in_byte == 8'h00) begin
                        n_mode = MODE_IDLE;
                    end else if (i_in_byte == CH_QUOTE) begin
                        n_mode     = MODE_IDLE;
                        o_cmd.kind = KIND_CLOSE;
                    end else if (i_in_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                        o_push = 1'b0;
                    end else begin
                        o_cmd.kind = KIND_DATA;
                        o_cmd.b0   = i_in_byte;
                    end
                end
                MODE_ESC: begin
                    o_push     = 1'b1;
                    n_mode     = MODE_STR;
                    o_cmd.kind = KIND_DATA;
                    case (i_in_byte)
                        CH_B:      o_cmd.b0 = 8'h08;
                        CH_F:      o_cmd.b0 = 8'h0C;
                        CH_N:      o_cmd.b0 = 8'h0A;
                        CH_R:      o_cmd.b0 = 8'h0D;
                        CH_T:      o_cmd.b0 = 8'h09;
                        CH_QUOTE:  o_cmd.b0 = CH_QUOTE;
                        CH_BSLASH: o_cmd.b0 = CH_BSLASH;
                        CH_SLASH:  o_cmd.b0 = CH_SLASH;
                        CH_U: begin
                            o_push    = 1'b0;
                            n_mode    = MODE_HEX;
                            n_accum   = '0;
                            n_hex_cnt = '0;
                        end
                        default: begin
                            n_mode     = MODE_IDLE;
                            o_cmd.kind = KIND_ERROR;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (!hex_ok) begin
                        o_push    = 1'b1;
                        n_mode    = MODE_IDLE;
                        n_accum   = '0;
                        n_hex_cnt = '0;
                    end else if (r_hex_cnt == 2'd3) begin
                        // Fourth digit completes the code point; encode it as UTF-8.
                        o_push     = 1'b1;
                        n_mode     = MODE_STR;
                        n_hex_cnt  = '0;
                        n_accum    = code[11:0];
                        o_cmd.kind = KIND_DATA;
                        if (code <= 16'h007F) begin
                            o_cmd.b0 = code[7:0];
                        end else if (code <= 16'h07FF) begin
                            o_cmd.count = 2'd2;
                            o_cmd.b0    = 8'hC0 | {3'b000, code[10:6]};
                            o_cmd.b1    = 8'h80 | {2'b00, code[5:0]};
                        end else begin
                            o_cmd.count = 2'd3;
                            o_cmd.b0    = 8'hE0 | {4'h0, code[15:12]};
                            o_cmd.b1    = 8'h80 | {2'b00, code[11:6]};
                            o_cmd.b2    = 8'h80 | {2'b00, code[5:0]};
                        end
                    end else begin
                        n_accum   = code[11:0];
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end
                end
                default: begin
                    if (i_in_byte == CH_QUOTE) begin
                        n_mode    = MODE_STR;
                        n_accum   = '0;
                        n_hex_cnt = '0;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            endcase
        end
    end

    // A partial hex count only exists while a unicode escape is open.
    `JSU_ASSERT_IMP(a_hexcnt_mode, i_clk, i_rst_n, r_hex_cnt != 2'd0, r_mode == MODE_HEX)

endmodule

`default_nettype wire

@@ rtl/jsu_queue.sv @@
// Small register queue of result commands between front and back ends.
// Depends on jsu_pkg and json_string_unescaper_macros.svh.
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_full,
    output logic      o_empty
);

    `include "json_string_unescaper_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `JSU_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `JSU_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

`default_nettype wire

@@ rtl/jsu_back.sv @@
// Back end of the unescaper: expands queued commands into single results.
// Depends on jsu_pkg and the macros header; drives the registered output channel.
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cmd            i_head,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic            o_last
);

    `include "json_string_unescaper_macros.svh"

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_kind      r_kind;
    logic       r_last;
    logic [1:0] r_idx, n_idx;
    logic       load;
    logic       final_one;
    logic [7:0] sel_byte;

    // The output register may take a new result when empty or being drained.
    assign load      = !r_out_valid || !i_stall;
    assign final_one = ((r_idx + 2'd1) == i_head.count);
    assign o_pop     = load && !i_empty && final_one;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
        n_idx = r_idx;
        if (load && !i_empty) begin
            n_idx = final_one ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_out_byte <= sel_byte;
            r_kind     <= i_head.kind;
            r_last     <= final_one;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_kind     = r_kind;
    assign o_last     = r_last;

    // A command being expanded stays at the head of the queue until its last byte.
    `JSU_ASSERT_IMP(a_partial_head, i_clk, i_rst_n, r_idx != 2'd0, !i_empty)
    `JSU_ASSERT_IMP(a_ctl_last, i_clk, i_rst_n, r_out_valid && r_kind != KIND_DATA,
        r_last && r_out_byte == 8'h00)

endmodule

`default_nettype wire

@@ rtl/json_string_unescaper.sv @@
// JSON string unescaper: one raw byte of a quoted string literal is accepted per
// cycle, with no result, one result, or up to three UTF-8 bytes for a unicode
// escape, each result tagged as data, string closed or format error and marked
// last on the final result of its input byte. Results pass the command queue and
// then the output register, which issues one result per cycle while i_stall is
// low, so a byte that expands to n results holds the output until all are issued;
// the command queue of QUEUE_DEPTH entries between parser and output absorbs such
// bursts, and input stalls only while that queue is full.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`default_nettype none

module json_string_unescaper
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic            o_last
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_stall = full;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_cmd     (front_cmd),
        .o_push    (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

@@ verif/json_string_unescaper_tb.sv @@
// Self-checking testbench for json_string_unescaper: random and directed string literals,
// a built-in unescaper that predicts every result, and random idling on both channels.
// Depends on jsu_pkg and the json_string_unescaper RTL.
`default_nettype none

module json_string_unescaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam int         STR_ITEMS  = 460;
    localparam int         TAIL_ITEMS = 60;
    localparam int         STUCK_LIMIT = 1000;
    localparam int         MAX_REPORTS = 10;

    // Letters that may follow a backslash and map to one byte: b f n r t quote backslash slash.
    localparam logic [7:0] ESC_LETTERS [8] = '{8'h62, 8'h66, 8'h6E, 8'h72, 8'h74,
                                               8'h22, 8'h5C, 8'h2F};

    typedef struct packed {
        logic [7:0] value;
        t_kind      kind;
        logic       last;
    } t_unescaped;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [7:0] i_in_byte  = 8'h00;
    logic       i_stall    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic       o_last;

    logic [7:0] pending_bytes[$];
    t_unescaped expected_results[$];

    // Predictor state.
    t_mode       str_mode  = MODE_IDLE;
    logic [15:0] code_acc  = 16'h0000;
    logic [1:0]  hex_seen  = 2'd0;

    int mismatches = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    int stuck_cycles = 0;

    json_string_unescaper DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void queue_result(input logic [7:0] value, input t_kind kind,
                                         input logic last);
        t_unescaped r;
        r.value = value;
        r.kind  = kind;
        r.last  = last;
        expected_results.push_back(r);
    endfunction

    function automatic void drop_to_idle();
        str_mode = MODE_IDLE;
        code_acc = 16'h0000;
        hex_seen = 2'd0;
        queue_result(8'h00, KIND_ERROR, 1'b1);
    endfunction

    // Advances the predictor by one accepted input byte and queues its results.
    function automatic void unescape_byte(input logic [7:0] c);
        logic [4:0]  nib;
        logic [15:0] cp;
        case (str_mode)
            MODE_STR: begin
                if (c == 8'h00) begin
                    drop_to_idle();
                end else if (c == QUOTE) begin
                    str_mode = MODE_IDLE;
                    queue_result(8'h00, KIND_CLOSE, 1'b1);
                end else if (c == BACKSLASH) begin
                    str_mode = MODE_ESC;
                end else begin
                    queue_result(c, KIND_DATA, 1'b1);
                end
            end
            MODE_ESC: begin
                str_mode = MODE_STR;
                case (c)
                    8'h62: queue_result(8'h08, KIND_DATA, 1'b1);
                    8'h66: queue_result(8'h0C, KIND_DATA, 1'b1);
                    8'h6E: queue_result(8'h0A, KIND_DATA, 1'b1);
                    8'h72: queue_result(8'h0D, KIND_DATA, 1'b1);
                    8'h74: queue_result(8'h09, KIND_DATA, 1'b1);
                    QUOTE, BACKSLASH, 8'h2F: queue_result(c, KIND_DATA, 1'b1);
                    8'h75: begin
                        str_mode = MODE_HEX;
                        code_acc = 16'h0000;
                        hex_seen = 2'd0;
                    end
                    default: drop_to_idle();
                endcase
            end
            MODE_HEX: begin
                if (c >= 8'h30 && c <= 8'h39) nib = 5'(c - 8'h30);
                else if (c >= 8'h61 && c <= 8'h66) nib = 5'(c - 8'h61 + 8'd10);
                else if (c >= 8'h41 && c <= 8'h46) nib = 5'(c - 8'h41 + 8'd10);
                else nib = 5'd16;
                if (nib[4]) begin
                    drop_to_idle();
                end else begin
                    code_acc = {code_acc[11:0], nib[3:0]};
                    if (hex_seen == 2'd3) begin
                        hex_seen = 2'd0;
                        str_mode = MODE_STR;
                        cp = code_acc;
                        if (cp <= 16'h007F) begin
                            queue_result(cp[7:0], KIND_DATA, 1'b1);
                        end else if (cp <= 16'h07FF) begin
                            queue_result({3'b110, cp[10:6]}, KIND_DATA, 1'b0);
                            queue_result({2'b10, cp[5:0]}, KIND_DATA, 1'b1);
                        end else begin
                            queue_result({4'b1110, cp[15:12]}, KIND_DATA, 1'b0);
                            queue_result({2'b10, cp[11:6]}, KIND_DATA, 1'b0);
                            queue_result({2'b10, cp[5:0]}, KIND_DATA, 1'b1);
                        end
                    end else begin
                        hex_seen = hex_seen + 2'd1;
                    end
                end
            end
            default: begin
                if (c == QUOTE) begin
                    str_mode = MODE_STR;
                    code_acc = 16'h0000;
                    hex_seen = 2'd0;
                end else begin
                    drop_to_idle();
                end
            end
        endcase
    endfunction

    // Backslash-u escape with the hex digits in a random mix of cases.
    task automatic push_unicode(input logic [15:0] cp);
        logic [3:0] nib;
        pending_bytes.push_back(BACKSLASH);
        pending_bytes.push_back(8'h75);
        for (int i = 3; i >= 0; i--) begin
            nib = cp[i*4 +: 4];
            if (nib < 4'd10) pending_bytes.push_back(8'h30 + nib);
            else if ($urandom_range(0, 1)) pending_bytes.push_back(8'h41 + nib - 8'd10);
            else pending_bytes.push_back(8'h61 + nib - 8'd10);
        end
    endtask

    task automatic push_plain();
        logic [7:0] b;
        b = QUOTE;
        while (b == QUOTE || b == BACKSLASH) b = 8'($urandom_range(1, 255));
        pending_bytes.push_back(b);
    endtask

    // Ends the current literal with a format fault of a random flavor.
    task automatic push_fault();
        logic [7:0] bad;
        logic       hit;
        int         digits;
        case ($urandom_range(0, 3))
            0: pending_bytes.push_back(8'h00);
            1: begin
                do begin
                    bad = 8'($urandom_range(0, 255));
                    hit = (bad == 8'h75);
                    foreach (ESC_LETTERS[k]) if (bad == ESC_LETTERS[k]) hit = 1'b1;
                end while (hit);
                pending_bytes.push_back(BACKSLASH);
                pending_bytes.push_back(bad);
            end
            2: begin
                do begin
                    bad = 8'($urandom_range(0, 255));
                end while ((bad >= 8'h30 && bad <= 8'h39) || (bad >= 8'h41 && bad <= 8'h46) ||
                           (bad >= 8'h61 && bad <= 8'h66));
                digits = $urandom_range(0, 3);
                pending_bytes.push_back(BACKSLASH);
                pending_bytes.push_back(8'h75);
                repeat (digits) pending_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
                pending_bytes.push_back(bad);
            end
            default: begin
                // Close properly, then a stray byte while idle.
                pending_bytes.push_back(QUOTE);
                bad = QUOTE;
                while (bad == QUOTE) bad = 8'($urandom_range(0, 255));
                pending_bytes.push_back(bad);
            end
        endcase
    endtask

    task automatic push_random_string();
        int seg_count;
        int break_at;
        logic broken;
        seg_count = $urandom_range(0, 8);
        broken    = ($urandom_range(0, 9) == 0);
        break_at  = $urandom_range(0, seg_count);
        pending_bytes.push_back(QUOTE);
        for (int s = 0; s <= seg_count; s++) begin
            if (broken && s == break_at) begin
                push_fault();
                return;
            end
            if (s == seg_count) break;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: push_plain();
                5, 6, 7: begin
                    pending_bytes.push_back(BACKSLASH);
                    pending_bytes.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: push_unicode(16'($urandom_range(16'h0000, 16'h007F)));
                        1: push_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
                        2: push_unicode(16'($urandom_range(16'h0800, 16'hFFFF)));
                        default: push_unicode(16'($urandom_range(16'hD800, 16'hDFFF)));
                    endcase
                end
            endcase
        end
        pending_bytes.push_back(QUOTE);
    endtask

    // Stimulus, reset and end of run.
    initial begin
        // Stray bytes while idle, both extremes.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(QUOTE);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(BACKSLASH);
        pending_bytes.push_back(8'h2F);
        push_unicode(16'h0000);
        push_unicode(16'hFFFF);
        pending_bytes.push_back(QUOTE);
        // Zero byte inside a string.
        pending_bytes.push_back(QUOTE);
        pending_bytes.push_back(8'h00);
        // Unknown escape letter.
        pending_bytes.push_back(QUOTE);
        pending_bytes.push_back(BACKSLASH);
        pending_bytes.push_back(8'h71);
        // Non-hex character after two good digits.
        pending_bytes.push_back(QUOTE);
        pending_bytes.push_back(BACKSLASH);
        pending_bytes.push_back(8'h75);
        pending_bytes.push_back(8'h41);
        pending_bytes.push_back(8'h66);
        pending_bytes.push_back(8'h67);
        while (pending_bytes.size() < STR_ITEMS) push_random_string();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (8) @(negedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Input driver: a new byte goes out once the previous transaction has completed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                unescape_byte(i_in_byte);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    i_valid <= 1'b0;
                end else begin
                    i_valid   <= 1'b1;
                    i_in_byte <= pending_bytes.pop_front();
                end
            end
        end
    end

    // Output monitor and receiver stall generator.
    always @(posedge i_clk) begin
        t_unescaped want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: byte %02h kind %0d last %0b",
                                 o_out_byte, o_kind, o_last);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_byte !== want.value || o_kind !== want.kind ||
                        o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: want %02h/%0d/%0b got %02h/%0d/%0b",
                                     want.value, want.kind, want.last,
                                     o_out_byte, o_kind, o_last);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (pending_bytes.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 5);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Ends the run if no transaction completes on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

endmodule

`default_nettype wire
